// ----- rtl/great_circle_distance_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the great-circle distance block
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_TOP_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_TOP_ASSERT_SVH

// same-cycle implication
`define GCD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("gcd implication check failed");

// implication into the next cycle
`define GCD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("gcd next-cycle check failed");

// implication after a fixed number of cycles
`define GCD_ASSERT_DLY(lbl, ck, rn, ante, n, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##n (cons)) \
		else $error("gcd delayed check failed");

`endif

// ----- rtl/gcd_pkg.sv -----
// ---------------------------------------------------------------------------
// gcd_pkg
// Constants, types and elaboration-time table functions for the
// great-circle distance pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package gcd_pkg;

	// field widths
	localparam int LAT_W    = 31;
	localparam int LON_W    = 32;
	localparam int RADIUS_W = 24;
	localparam int DIST_W   = 26;
	localparam int OPND_W   = 33;

	typedef logic [RADIUS_W-1:0] radius_t;
	typedef logic [DIST_W-1:0]   dist_t;

	localparam radius_t RADIUS_RESET = 24'd6371000;
	localparam dist_t   DIST_MAX     = 26'h3FFFFFF;

	// pi at 61 fraction bits, degree-to-radian factor at the same scale
	localparam longint PI_Q61 = 64'h6487ED5110B4611A;
	localparam longint D2R    = PI_Q61 / 180;

	// degree-to-radian factor split into two halves for narrow multipliers
	localparam int D2R_HW = 28;
	localparam logic [D2R_HW-1:0] D2R_HI = D2R_HW'(D2R >> D2R_HW);
	localparam logic [D2R_HW-1:0] D2R_LO = D2R_HW'(D2R);

	// shift-subtract division, elaboration only
	function automatic longint unsigned div_c(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q;
		longint unsigned rem;
		int b;
		q = 0;
		rem = 0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// arctangent of 2^-i from its series at 62 fraction bits, cut to f bits
	function automatic longint atan_c(input int i, input int f);
		longint sum;
		longint term;
		int k;
		int e;
		sum = 0;
		if (i == 0) begin
			sum = PI_Q61 >>> 1;
		end else begin
			for (k = 0; k < 32; k++) begin
				e = i * (2 * k + 1);
				if (e <= 62) begin
					term = longint'(div_c(64'd1 << (62 - e), 64'(2 * k + 1)));
					if (k[0]) sum = sum - term;
					else sum = sum + term;
				end
			end
		end
		return sum >>> (62 - f);
	endfunction

	// (a * b) >> f truncated toward zero, elaboration only
	function automatic longint mulq_c(input longint a, input longint b, input int f);
		logic [127:0] p;
		longint unsigned ua;
		longint unsigned ub;
		longint unsigned r;
		bit neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? longint'(-a) : a;
		ub = (b < 0) ? longint'(-b) : b;
		p = 128'(ua) * 128'(ub);
		r = 64'(p >> f) & 64'h7FFFFFFFFFFFFFFF;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	// inverse CORDIC gain by Newton steps on the squared gain
	function automatic longint gain_inv_c(input int iters, input int f);
		longint one;
		longint g2;
		longint r;
		int i;
		one = 64'sd1 <<< f;
		g2 = one;
		for (i = 0; i < iters; i++) begin
			if (2 * i < 63) g2 = g2 + (g2 >>> (2 * i));
		end
		r = (one * 3) / 5;
		for (i = 0; i < 8; i++) begin
			r = mulq_c(r, 3 * one - mulq_c(g2, mulq_c(r, r, f), f), f) >>> 1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/gcd_cordic_cell.sv -----
// ---------------------------------------------------------------------------
// gcd_cordic_cell
// One CORDIC micro-rotation with its output registered; rotation mode
// steers on the residual angle, vectoring mode steers on y.
// ---------------------------------------------------------------------------
`default_nettype none

module gcd_cordic_cell import gcd_pkg::*; #(
	parameter int     W         = 34,
	parameter int     SHIFT     = 0,
	parameter longint ATAN      = 0,
	parameter bit     VECTORING = 1'b0
) (
	input  logic                clk,
	input  logic signed [W-1:0] x,
	input  logic signed [W-1:0] y,
	input  logic signed [W-1:0] z,
	input  logic                flag,
	output logic signed [W-1:0] x_next,
	output logic signed [W-1:0] y_next,
	output logic signed [W-1:0] z_next,
	output logic                flag_next
);

	localparam logic signed [W-1:0] ATAN_W = W'(ATAN);

	logic signed [W-1:0] xs;
	logic signed [W-1:0] ys;
	logic                dir;
	logic signed [W-1:0] x_q;
	logic signed [W-1:0] y_q;
	logic signed [W-1:0] z_q;
	logic                flag_q;

	// direction: rotate toward zero angle or toward zero y
	always_comb begin
		xs = x >>> SHIFT;
		ys = y >>> SHIFT;
		if (VECTORING) dir = y[W-1] || (y == '0);
		else dir = !z[W-1];
	end

	always_ff @(posedge clk) begin
		if (dir) begin
			x_q <= x - ys;
			y_q <= y + xs;
			z_q <= z - ATAN_W;
		end else begin
			x_q <= x + ys;
			y_q <= y - xs;
			z_q <= z + ATAN_W;
		end
		flag_q <= flag;
	end

	assign x_next    = x_q;
	assign y_next    = y_q;
	assign z_next    = z_q;
	assign flag_next = flag_q;

endmodule

`default_nettype wire

// ----- rtl/gcd_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// gcd_sqrt_cell
// One bit of a restoring integer square root: tries bit B of the root
// against the running remainder, output registered.
// ---------------------------------------------------------------------------
`default_nettype none

module gcd_sqrt_cell import gcd_pkg::*; #(
	parameter int RW = 64,
	parameter int RT = 32,
	parameter int B  = 0
) (
	input  logic          clk,
	input  logic [RW-1:0] rem,
	input  logic [RT-1:0] root,
	output logic [RW-1:0] rem_next,
	output logic [RT-1:0] root_next
);

	logic [RW-1:0] trial;
	logic [RW-1:0] rem_q;
	logic [RT-1:0] root_q;

	// (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
	assign trial = (RW'(root) << (B + 1)) + (RW'(1) << (2 * B));

	always_ff @(posedge clk) begin
		if (rem >= trial) begin
			rem_q  <= rem - trial;
			root_q <= root | (RT'(1) << B);
		end else begin
			rem_q  <= rem;
			root_q <= root;
		end
	end

	assign rem_next  = rem_q;
	assign root_next = root_q;

endmodule

`default_nettype wire

// ----- rtl/gcd_mulq.sv -----
// ---------------------------------------------------------------------------
// gcd_mulq
// Registered fixed-point multiply: (a * b) >> F, truncated toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module gcd_mulq import gcd_pkg::*; #(
	parameter int W = 34,
	parameter int F = 30
) (
	input  logic                clk,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] p
);

	logic [W-1:0]        ua;
	logic [W-1:0]        ub;
	logic [2*W-1:0]      prod;
	logic [W-1:0]        mag;
	logic                neg;
	logic signed [W-1:0] p_q;

	// sign-magnitude product so the shift truncates toward zero
	always_comb begin
		neg  = a[W-1] ^ b[W-1];
		ua   = a[W-1] ? W'(-a) : W'(a);
		ub   = b[W-1] ? W'(-b) : W'(b);
		prod = (2 * W)'(ua) * (2 * W)'(ub);
		mag  = W'(prod >> F);
	end

	always_ff @(posedge clk) begin
		p_q <= neg ? -$signed(mag) : $signed(mag);
	end

	assign p = p_q;

endmodule

`default_nettype wire

// ----- rtl/great_circle_distance_top.sv -----
// ---------------------------------------------------------------------------
// great_circle_distance_top
// Haversine great-circle distance between two points, fully pipelined
// through chains of CORDIC and square-root cells.
// ---------------------------------------------------------------------------
//  channel   signals                              handshake
//  input     start, lat_a, lon_a, lat_b, lon_b    start && !busy
//  result    done, distance_m                     done strobe, one cycle
//  config    cfg_we, cfg_wdata                    cfg_we
//
// One item per cycle while busy is low. Pipeline depth is set by the two
// CORDIC cell chains and the square-root chain of ANGLE_FRAC_BITS+2 cells.
// busy is high only in reset and the first cycle after it. Results cannot
// be stalled; the strobe is final.
// ---------------------------------------------------------------------------
`default_nettype none

module great_circle_distance_top import gcd_pkg::*; #(
	parameter int ITERATIONS      = 24,
	parameter int ANGLE_FRAC_BITS = 30
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [LAT_W-1:0] lat_a,
	input  logic signed [LON_W-1:0] lon_a,
	input  logic signed [LAT_W-1:0] lat_b,
	input  logic signed [LON_W-1:0] lon_b,
	output logic                    done,
	output dist_t                   distance_m,
	input  logic                    cfg_we,
	input  radius_t                 cfg_wdata
);

	localparam int F       = ANGLE_FRAC_BITS;
	localparam int I       = ITERATIONS;
	localparam int W       = F + 4;
	localparam int RW      = 2 * F + 4;
	localparam int RT      = F + 2;
	localparam int NSQ     = F + 2;
	localparam int PP_W    = OPND_W + D2R_HW;
	localparam int P_W     = OPND_W + 2 * D2R_HW;
	localparam int SH      = 84 - F;
	localparam int CW      = W - 1;
	localparam int DP_W    = RADIUS_W + CW;
	localparam int LATENCY = 2 * I + F + 15;

	localparam logic signed [W-1:0] PI_W   = W'(PI_Q61 >> (61 - F));
	localparam logic signed [W-1:0] TWO_PI = PI_W <<< 1;
	localparam logic signed [W-1:0] HALF_PI = PI_W >>> 1;
	localparam logic signed [W-1:0] ONE_W  = W'(64'sd1 <<< F);
	localparam logic signed [W-1:0] GAIN_W = W'(gain_inv_c(I, F));

	// control
	logic               busy_q;
	logic               accept;
	logic [LATENCY-1:0] vld_q;
	radius_t            radius_q;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = vld_q[LATENCY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			vld_q    <= '0;
			radius_q <= RADIUS_RESET;
		end else begin
			busy_q <= 1'b0;
			vld_q  <= {vld_q[LATENCY-2:0], accept};
			if (cfg_we) radius_q <= cfg_wdata;
		end
	end

	// angle operands: latitude and longitude differences, both latitudes
	logic signed [OPND_W-1:0] opnd [4];

	always_comb begin
		opnd[0] = OPND_W'(lat_b) - OPND_W'(lat_a);
		opnd[1] = OPND_W'(lon_b) - OPND_W'(lon_a);
		opnd[2] = OPND_W'(lat_a);
		opnd[3] = OPND_W'(lat_b);
	end

	logic [OPND_W-1:0]   mag_s1 [4];
	logic                neg_s1 [4];
	logic [PP_W-1:0]     pph_s2 [4];
	logic [PP_W-1:0]     ppl_s2 [4];
	logic                neg_s2 [4];
	logic signed [W-1:0] th_s3  [4];
	logic signed [W-1:0] th_s4  [4];
	logic signed [W-1:0] th_s5  [4];
	logic                flip_s5 [4];

	logic signed [W-1:0] rx [4][I+1];
	logic signed [W-1:0] ry [4][I+1];
	logic signed [W-1:0] rz [4][I+1];
	logic                rf [4][I+1];

	for (genvar l = 0; l < 4; l++) begin : g_lane
		// differences are halved for the haversine
		localparam int LSH = (l < 2) ? SH + 1 : SH;

		logic [P_W-1:0] psum;
		logic [P_W-1:0] pshr;
		logic [W-2:0]   thm;

		always_comb begin
			psum = (P_W'(pph_s2[l]) << D2R_HW) + P_W'(ppl_s2[l]);
			pshr = psum >> LSH;
			thm  = pshr[W-2:0];
		end

		// degrees to radians, reduce to [-pi, pi], fold to [-pi/2, pi/2]
		always_ff @(posedge clk) begin
			mag_s1[l] <= opnd[l][OPND_W-1] ? OPND_W'(-opnd[l]) : OPND_W'(opnd[l]);
			neg_s1[l] <= opnd[l][OPND_W-1];
			pph_s2[l] <= PP_W'(mag_s1[l]) * PP_W'(D2R_HI);
			ppl_s2[l] <= PP_W'(mag_s1[l]) * PP_W'(D2R_LO);
			neg_s2[l] <= neg_s1[l];
			th_s3[l]  <= neg_s2[l] ? -$signed({1'b0, thm}) : $signed({1'b0, thm});
			if (th_s3[l] > PI_W) th_s4[l] <= th_s3[l] - TWO_PI;
			else if (th_s3[l] < -PI_W) th_s4[l] <= th_s3[l] + TWO_PI;
			else th_s4[l] <= th_s3[l];
			if (th_s4[l] > HALF_PI) begin
				th_s5[l]   <= th_s4[l] - PI_W;
				flip_s5[l] <= 1'b1;
			end else if (th_s4[l] < -HALF_PI) begin
				th_s5[l]   <= th_s4[l] + PI_W;
				flip_s5[l] <= 1'b1;
			end else begin
				th_s5[l]   <= th_s4[l];
				flip_s5[l] <= 1'b0;
			end
		end

		assign rx[l][0] = GAIN_W;
		assign ry[l][0] = '0;
		assign rz[l][0] = th_s5[l];
		assign rf[l][0] = flip_s5[l];

		// rotation-mode sine/cosine chain
		for (genvar i = 0; i < I; i++) begin : g_rot
			gcd_cordic_cell #(
				.W(W), .SHIFT(i), .ATAN(atan_c(i, F)), .VECTORING(1'b0)
			) u_cell (
				.clk(clk),
				.x(rx[l][i]), .y(ry[l][i]), .z(rz[l][i]), .flag(rf[l][i]),
				.x_next(rx[l][i+1]), .y_next(ry[l][i+1]),
				.z_next(rz[l][i+1]), .flag_next(rf[l][i+1])
			);
		end
	end

	// undo the half-turn fold: sines of half differences, cosines of latitudes
	logic signed [W-1:0] sn1_s6;
	logic signed [W-1:0] sn2_s6;
	logic signed [W-1:0] cs1_s6;
	logic signed [W-1:0] cs2_s6;

	always_ff @(posedge clk) begin
		sn1_s6 <= rf[0][I] ? -ry[0][I] : ry[0][I];
		sn2_s6 <= rf[1][I] ? -ry[1][I] : ry[1][I];
		cs1_s6 <= rf[2][I] ? -rx[2][I] : rx[2][I];
		cs2_s6 <= rf[3][I] ? -rx[3][I] : rx[3][I];
	end

	// haversine term a = s1^2 + c1*c2*s2^2
	logic signed [W-1:0] p1_s7;
	logic signed [W-1:0] p2_s7;
	logic signed [W-1:0] p3_s7;
	logic signed [W-1:0] p1_s8;
	logic signed [W-1:0] p4_s8;
	logic signed [W-1:0] asum;
	logic signed [W-1:0] a_s9;

	gcd_mulq #(.W(W), .F(F)) u_mul_s1 (.clk(clk), .a(sn1_s6), .b(sn1_s6), .p(p1_s7));
	gcd_mulq #(.W(W), .F(F)) u_mul_cc (.clk(clk), .a(cs1_s6), .b(cs2_s6), .p(p2_s7));
	gcd_mulq #(.W(W), .F(F)) u_mul_s2 (.clk(clk), .a(sn2_s6), .b(sn2_s6), .p(p3_s7));
	gcd_mulq #(.W(W), .F(F)) u_mul_p4 (.clk(clk), .a(p2_s7), .b(p3_s7), .p(p4_s8));

	assign asum = p1_s8 + p4_s8;

	always_ff @(posedge clk) begin
		p1_s8 <= p1_s7;
		if (asum[W-1]) a_s9 <= '0;
		else if (asum > ONE_W) a_s9 <= ONE_W;
		else a_s9 <= asum;
	end

	// square roots of a and 1-a, one root bit per cell
	logic [RW-1:0] srem  [2][NSQ+1];
	logic [RT-1:0] sroot [2][NSQ+1];
	logic [RW-1:0] rem_y_s10;
	logic [RW-1:0] rem_x_s10;
	logic signed [W-1:0] one_minus_a;

	assign one_minus_a = ONE_W - a_s9;

	always_ff @(posedge clk) begin
		rem_y_s10 <= RW'($unsigned(a_s9)) << F;
		rem_x_s10 <= RW'($unsigned(one_minus_a)) << F;
	end

	assign srem[0][0]  = rem_y_s10;
	assign srem[1][0]  = rem_x_s10;
	assign sroot[0][0] = '0;
	assign sroot[1][0] = '0;

	for (genvar s = 0; s < 2; s++) begin : g_sqrt
		for (genvar j = 0; j < NSQ; j++) begin : g_bit
			gcd_sqrt_cell #(.RW(RW), .RT(RT), .B(NSQ - 1 - j)) u_cell (
				.clk(clk),
				.rem(srem[s][j]), .root(sroot[s][j]),
				.rem_next(srem[s][j+1]), .root_next(sroot[s][j+1])
			);
		end
	end

	// vectoring chain: z = atan2(sqrt(a), sqrt(1-a))
	logic signed [W-1:0] vx [I+1];
	logic signed [W-1:0] vy [I+1];
	logic signed [W-1:0] vz [I+1];

	assign vx[0] = $signed(W'(sroot[1][NSQ]));
	assign vy[0] = $signed(W'(sroot[0][NSQ]));
	assign vz[0] = '0;

	for (genvar i = 0; i < I; i++) begin : g_vec
		gcd_cordic_cell #(
			.W(W), .SHIFT(i), .ATAN(atan_c(i, F)), .VECTORING(1'b1)
		) u_cell (
			.clk(clk),
			.x(vx[i]), .y(vy[i]), .z(vz[i]), .flag(1'b0),
			.x_next(vx[i+1]), .y_next(vy[i+1]), .z_next(vz[i+1]), .flag_next()
		);
	end

	// central angle, scale by radius, truncate and saturate
	logic signed [W-1:0] z2;
	logic [CW-1:0]       c_s11;
	logic [DP_W-1:0]     prod_s12;
	logic [DP_W-F-1:0]   dist_w;
	dist_t               dist_s13;

	assign z2     = vz[I] <<< 1;
	assign dist_w = (DP_W - F)'(prod_s12 >> F);

	always_ff @(posedge clk) begin
		c_s11    <= z2[W-1] ? '0 : z2[CW-1:0];
		prod_s12 <= DP_W'(radius_q) * DP_W'(c_s11);
		if (dist_w > (DP_W - F)'(DIST_MAX)) dist_s13 <= DIST_MAX;
		else dist_s13 <= DIST_W'(dist_w);
	end

	assign distance_m = dist_s13;

endmodule

`default_nettype wire

// ----- rtl/gcd_checker.sv -----
// ---------------------------------------------------------------------------
// gcd_checker
// Port-level timing checks for the great-circle distance block, bound
// to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "great_circle_distance_top_assert.svh"

module gcd_checker #(
	parameter int LAT = 93
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// every result strobe traces back to an item taken at the input
	`GCD_ASSERT_IMP(a_done_has_item, clk, arst_n, done, $past(start && !busy, LAT))

	// no item taken means no matching result strobe at the output
	`GCD_ASSERT_DLY(a_no_item_no_done, clk, arst_n, !(start && !busy), LAT, !done)

	// once ready, the block stays ready
	`GCD_ASSERT_NXT(a_busy_stays_low, clk, arst_n, !busy, !busy)

endmodule

bind great_circle_distance_top gcd_checker #(.LAT(LATENCY)) u_gcd_checker (.*);

`default_nettype wire
